### rtl/core/oxc_pkg.sv
// Shared constants and types for the order crossover block.
package oxc_pkg;

  localparam int MAX_CITIES = 64;
  localparam int ID_BITS    = 12;
  localparam int ADDR_W     = $clog2(MAX_CITIES);
  localparam int CNT_W      = $clog2(MAX_CITIES + 1);
  localparam int LO_W       = 5;
  localparam int HI_W       = 6;
  localparam int MAP_DEPTH  = 2 ** ID_BITS;

  typedef struct packed {
    logic [ID_BITS-1:0] parent_a_id;
    logic [ID_BITS-1:0] parent_b_id;
    logic [LO_W-1:0]    cut_low;
    logic [HI_W-1:0]    cut_high;
    logic               last;
  } in_beat_t;

  typedef struct packed {
    logic [ID_BITS-1:0] child_a_id;
    logic [ID_BITS-1:0] child_b_id;
    logic               out_last;
  } out_beat_t;

  // Tour length and ordered, clamped cut points handed to the engine.
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
  } xo_cmd_t;

  // Shared read request for both parent memories.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } prd_req_t;

endpackage

### rtl/core/oxc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module oxc_ram #(
  parameter int WIDTH  = 12,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/oxc_engine.sv
// Crossover sequencer: child memories, id presence map and result register.
module oxc_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  oxc_pkg::xo_cmd_t           cmd,
  output oxc_pkg::prd_req_t          prd,
  input  logic [oxc_pkg::ID_BITS-1:0] pa_rdata,
  input  logic [oxc_pkg::ID_BITS-1:0] pb_rdata,
  output logic                       idle,
  output logic                       out_valid,
  input  logic                       out_ready,
  output oxc_pkg::out_beat_t         out_data
);
  import oxc_pkg::*;

  typedef enum logic [9:0] {
    S_INIT      = 10'b00_0000_0001,
    S_IDLE      = 10'b00_0000_0010,
    S_COPY      = 10'b00_0000_0100,
    S_FREAD     = 10'b00_0000_1000,
    S_MREAD     = 10'b00_0001_0000,
    S_FDEC      = 10'b00_0010_0000,
    S_CLR       = 10'b00_0100_0000,
    S_EMIT_RD   = 10'b00_1000_0000,
    S_EMIT_LD   = 10'b01_0000_0000,
    S_EMIT_HOLD = 10'b10_0000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0]   hi_r, hi_nxt;
  logic               sel_r, sel_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               pipe_vld_r, pipe_vld_nxt;
  logic [ADDR_W-1:0]  pipe_addr_r, pipe_addr_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [ID_BITS-1:0] init_r, init_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_data_r, out_data_nxt;

  // memory ports
  logic               ch_we;
  logic [ADDR_W-1:0]  ch_waddr;
  logic [ID_BITS-1:0] ch_wdata;
  logic               ch_re;
  logic [ADDR_W-1:0]  ch_raddr;
  logic [ID_BITS-1:0] ca_rdata, cb_rdata;
  logic               map_we;
  logic [ID_BITS-1:0] map_waddr;
  logic               map_wdata;
  logic               map_re;
  logic [ID_BITS-1:0] map_raddr;
  logic               map_rdata;

  logic [ID_BITS-1:0] own_d, other_d, ch_rdata_sel;
  logic [CNT_W-1:0]   pipe_addr_x, idx_inc;
  logic               in_seg;
  logic [CNT_W-1:0]   p1, p2, p3, ptr_adv;

  oxc_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_CITIES)) u_child_a (
    .clk(clk), .we(ch_we & ~sel_r), .waddr(ch_waddr), .wdata(ch_wdata),
    .re(ch_re), .raddr(ch_raddr), .rdata(ca_rdata)
  );

  oxc_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_CITIES)) u_child_b (
    .clk(clk), .we(ch_we & sel_r), .waddr(ch_waddr), .wdata(ch_wdata),
    .re(ch_re), .raddr(ch_raddr), .rdata(cb_rdata)
  );

  // one bit per id: set while that id sits in the child being built
  oxc_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .re(map_re), .raddr(map_raddr), .rdata(map_rdata)
  );

  assign own_d        = sel_r ? pb_rdata : pa_rdata;
  assign other_d      = sel_r ? pa_rdata : pb_rdata;
  assign ch_rdata_sel = sel_r ? cb_rdata : ca_rdata;
  assign pipe_addr_x  = CNT_W'(pipe_addr_r);
  assign in_seg       = (pipe_addr_x >= lo_r) && (pipe_addr_x < hi_r);
  assign idx_inc      = idx_r + 1'b1;

  // fill pointer walks hi..n-1, wraps to 0, hops over the copied segment
  assign p1      = ptr_r + 1'b1;
  assign p2      = (p1 == n_r) ? '0 : p1;
  assign p3      = ((p2 == lo_r) && (lo_r != hi_r)) ? hi_r : p2;
  assign ptr_adv = (p3 == n_r) ? '0 : p3;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    sel_nxt       = sel_r;
    idx_nxt       = idx_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    pipe_vld_nxt  = 1'b0;
    pipe_addr_nxt = pipe_addr_r;
    id_nxt        = id_r;
    init_nxt      = init_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    prd           = '0;
    ch_we         = 1'b0;
    ch_waddr      = pipe_addr_r;
    ch_wdata      = '0;
    ch_re         = 1'b0;
    ch_raddr      = idx_r[ADDR_W-1:0];
    map_we        = 1'b0;
    map_waddr     = id_r;
    map_wdata     = 1'b0;
    map_re        = 1'b0;
    map_raddr     = other_d;

    case (state_r)
      S_INIT: begin
        map_we    = 1'b1;
        map_waddr = init_r;
        init_nxt  = init_r + 1'b1;
        if (&init_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          n_nxt     = cmd.n;
          lo_nxt    = cmd.lo;
          hi_nxt    = cmd.hi;
          sel_nxt   = 1'b0;
          idx_nxt   = '0;
          state_nxt = S_COPY;
        end
      end
      S_COPY: begin
        // write slot from last cycle's read: segment keeps own id, rest zero
        if (pipe_vld_r) begin
          ch_we = 1'b1;
          ch_wdata = in_seg ? own_d : '0;
          if (in_seg) begin
            map_we    = 1'b1;
            map_waddr = own_d;
            map_wdata = 1'b1;
          end
        end
        if (idx_r != n_r) begin
          prd.en        = 1'b1;
          prd.addr      = idx_r[ADDR_W-1:0];
          pipe_vld_nxt  = 1'b1;
          pipe_addr_nxt = idx_r[ADDR_W-1:0];
          idx_nxt       = idx_inc;
        end else begin
          idx_nxt   = '0;
          cnt_nxt   = hi_r - lo_r;
          ptr_nxt   = (hi_r == n_r) ? '0 : hi_r;
          state_nxt = S_FREAD;
        end
      end
      S_FREAD: begin
        if ((idx_r == n_r) || (cnt_r == n_r)) begin
          idx_nxt   = '0;
          state_nxt = S_CLR;
        end else begin
          prd.en    = 1'b1;
          prd.addr  = idx_r[ADDR_W-1:0];
          state_nxt = S_MREAD;
        end
      end
      S_MREAD: begin
        map_re    = 1'b1;
        id_nxt    = other_d;
        state_nxt = S_FDEC;
      end
      S_FDEC: begin
        if (!map_rdata) begin
          ch_we     = 1'b1;
          ch_waddr  = ptr_r[ADDR_W-1:0];
          ch_wdata  = id_r;
          map_we    = 1'b1;
          map_wdata = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          ptr_nxt   = ptr_adv;
        end
        idx_nxt   = idx_inc;
        state_nxt = S_FREAD;
      end
      S_CLR: begin
        // drop every id of the finished child from the map
        if (pipe_vld_r) begin
          map_we    = 1'b1;
          map_waddr = ch_rdata_sel;
        end
        if (idx_r != n_r) begin
          ch_re        = 1'b1;
          pipe_vld_nxt = 1'b1;
          idx_nxt      = idx_inc;
        end else begin
          idx_nxt = '0;
          if (!sel_r) begin
            sel_nxt   = 1'b1;
            state_nxt = S_COPY;
          end else begin
            state_nxt = S_EMIT_RD;
          end
        end
      end
      S_EMIT_RD: begin
        ch_re     = 1'b1;
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        out_valid_nxt         = 1'b1;
        out_data_nxt.child_a_id = ca_rdata;
        out_data_nxt.child_b_id = cb_rdata;
        out_data_nxt.out_last   = (idx_inc == n_r);
        state_nxt             = S_EMIT_HOLD;
      end
      S_EMIT_HOLD: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_data_r.out_last) begin
            state_nxt = S_IDLE;
          end else begin
            ch_re     = 1'b1;
            ch_raddr  = idx_inc[ADDR_W-1:0];
            idx_nxt   = idx_inc;
            state_nxt = S_EMIT_LD;
          end
        end
      end
      default: begin
        init_nxt      = '0;
        out_valid_nxt = 1'b0;
        state_nxt     = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_r      <= '0;
      pipe_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    ptr_r       <= ptr_nxt;
    cnt_r       <= cnt_nxt;
    pipe_addr_r <= pipe_addr_nxt;
    id_r        <= id_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/order_crossover_permutation.sv
// Order crossover (OX1) top level: parent loader, parent memories, engine.
//
// Parent tours stream in one position per input beat, one beat per cycle
// while in_ready is high, into two 64-entry parent memories; positions past
// 64 are dropped. The beat with last set closes the tour (length n, its own
// position included unless 64 are already held), its cut points are ordered
// and clamped to n, and the crossover engine runs with in_ready low. Each
// child is built in a presence map (one bit per node id): a copy pass, a
// fill walk that reads, looks up and places each scanned id of the other
// parent, and a clear pass; child a, then child b. The n result beats then
// follow one at a time, each held until out_ready takes it. After reset the
// presence map is zeroed one id per cycle, all 4096 ids, before in_ready
// first rises. The output beat sits in a register; the block takes no input
// while results are due.
module order_crossover_permutation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  oxc_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output oxc_pkg::out_beat_t out_data
);
  import oxc_pkg::*;

  logic [CNT_W-1:0]   load_cnt_r, load_cnt_nxt;
  logic               accept;
  logic               full;
  logic               pwe;
  logic               start;
  logic               eng_idle;
  logic [CNT_W-1:0]   lo_e, hi_e, lo_o, hi_o, n_cmd;
  xo_cmd_t            cmd;
  prd_req_t           prd;
  logic [ID_BITS-1:0] pa_rdata, pb_rdata;

  assign in_ready = eng_idle;
  assign accept   = in_valid && in_ready;
  assign full     = (load_cnt_r == CNT_W'(MAX_CITIES));
  assign pwe      = accept && !full;
  assign start    = accept && in_data.last;

  // tour length includes the closing beat unless the tour is already full
  assign n_cmd = full ? load_cnt_r : load_cnt_r + 1'b1;

  // order the cuts, then clamp both to the tour length
  assign lo_e = CNT_W'(in_data.cut_low);
  assign hi_e = CNT_W'(in_data.cut_high);
  assign lo_o = (lo_e > hi_e) ? hi_e : lo_e;
  assign hi_o = (lo_e > hi_e) ? lo_e : hi_e;
  assign cmd.n  = n_cmd;
  assign cmd.lo = (lo_o > n_cmd) ? n_cmd : lo_o;
  assign cmd.hi = (hi_o > n_cmd) ? n_cmd : hi_o;

  always_comb begin
    load_cnt_nxt = load_cnt_r;
    if (accept) begin
      if (in_data.last) begin
        load_cnt_nxt = '0;
      end else if (!full) begin
        load_cnt_nxt = load_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
    end else begin
      load_cnt_r <= load_cnt_nxt;
    end
  end

  oxc_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_CITIES)) u_par_a (
    .clk(clk), .we(pwe), .waddr(load_cnt_r[ADDR_W-1:0]),
    .wdata(in_data.parent_a_id),
    .re(prd.en), .raddr(prd.addr), .rdata(pa_rdata)
  );

  oxc_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_CITIES)) u_par_b (
    .clk(clk), .we(pwe), .waddr(load_cnt_r[ADDR_W-1:0]),
    .wdata(in_data.parent_b_id),
    .re(prd.en), .raddr(prd.addr), .rdata(pb_rdata)
  );

  oxc_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .cmd      (cmd),
    .prd      (prd),
    .pa_rdata (pa_rdata),
    .pb_rdata (pb_rdata),
    .idle     (eng_idle),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

### rtl/core/oxc_check.sv
// Port-level checker for the order crossover block, bound to the top level.
module oxc_check (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input oxc_pkg::in_beat_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input oxc_pkg::out_beat_t out_data
);
  import oxc_pkg::*;

  // reset leaves nothing to deliver and the map clear still ahead
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("beat offered right after reset");

  // no input is taken while results of a tour are outstanding
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result beat is pending");

  // the closing beat starts the crossover and closes the input side
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last |=> !in_ready)
    else $error("input still ready after closing beat");

  // the final result beat hands the block back to the loader
  a_final_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.out_last |=> in_ready && !out_valid)
    else $error("block not ready after final result beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

endmodule

bind order_crossover_permutation oxc_check u_oxc_check (.*);
